// ===== rtl/core/frsa_pkg.sv =====
// shared types, widths and codes for the rhs scatter accumulator
package frsa_pkg;

  localparam int unsigned DOF_COUNT = 4096;
  localparam int unsigned ADDR_W    = (DOF_COUNT > 1) ? $clog2(DOF_COUNT) : 1;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SUM_W     = 48;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_ACC   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_RDCLR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef struct packed {
    sum_t x;
    sum_t y;
    sum_t z;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
  } store_req_t;

endpackage

// ===== rtl/core/frsa_term.sv =====
// pipelined term unit: rounded, saturated weight * value * basis per component
module frsa_term (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  frsa_pkg::val_t      weight,
  input  frsa_pkg::val_t      basis_value,
  input  frsa_pkg::val_t      value_x,
  input  frsa_pkg::val_t      value_y,
  input  frsa_pkg::val_t      value_z,
  output logic                term_valid,
  output frsa_pkg::entry_t    term
);

  localparam logic [63:0] NEG_LIM = 64'(1) << (frsa_pkg::SUM_W - 1);
  localparam logic [63:0] POS_LIM = NEG_LIM - 64'(1);
  localparam logic [63:0] HALF    = 64'h0000_0000_8000_0000;

  logic [4:0]  vld_r;
  logic [31:0] val_in   [3];
  logic [31:0] mw_r;
  logic [31:0] mb1_r;
  logic [31:0] mb2_r;
  logic [31:0] mv_r     [3];
  logic        neg1_r   [3];
  logic        neg2_r   [3];
  logic        neg3_r   [3];
  logic        neg4_r   [3];
  logic [63:0] m_r      [3];
  logic [63:0] ph_r     [3];
  logic [63:0] pl_r     [3];
  logic [63:0] ph4_r    [3];
  logic [31:0] lohi_r   [3];
  logic [63:0] lo       [3];
  logic [63:0] mag      [3];
  frsa_pkg::sum_t term_nxt [3];
  frsa_pkg::sum_t term_r   [3];

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  assign val_in[0] = value_x;
  assign val_in[1] = value_y;
  assign val_in[2] = value_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lo[c]  = pl_r[c] + HALF;
      mag[c] = ph4_r[c] + 64'(lohi_r[c]);
      if (neg4_r[c]) begin
        term_nxt[c] = (mag[c] >= NEG_LIM) ? frsa_pkg::SUM_MIN : -mag[c][frsa_pkg::SUM_W-1:0];
      end else begin
        term_nxt[c] = (mag[c] > POS_LIM) ? frsa_pkg::SUM_MAX : mag[c][frsa_pkg::SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    mw_r  <= mag32(weight);
    mb1_r <= mag32(basis_value);
    mb2_r <= mb1_r;
    for (int c = 0; c < 3; c++) begin
      mv_r[c]   <= mag32(val_in[c]);
      neg1_r[c] <= weight[31] ^ val_in[c][31] ^ basis_value[31];
      neg2_r[c] <= neg1_r[c];
      neg3_r[c] <= neg2_r[c];
      neg4_r[c] <= neg3_r[c];
      m_r[c]    <= 64'(mw_r) * 64'(mv_r[c]);
      ph_r[c]   <= 64'(m_r[c][63:32]) * 64'(mb2_r);
      pl_r[c]   <= 64'(m_r[c][31:0]) * 64'(mb2_r);
      ph4_r[c]  <= ph_r[c];
      lohi_r[c] <= lo[c][63:32];
      term_r[c] <= term_nxt[c];
    end
  end

  assign term_valid = vld_r[4];
  assign term.x     = term_r[0];
  assign term.y     = term_r[1];
  assign term.z     = term_r[2];

endmodule

// ===== rtl/core/frsa_store.sv =====
// accumulator store: one write port, one registered read port
module frsa_store (
  input  logic                  clk,
  input  frsa_pkg::store_req_t  req,
  output frsa_pkg::entry_t      rd_data
);

  frsa_pkg::entry_t mem [frsa_pkg::DOF_COUNT];
  frsa_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/fem_rhs_scatter_accumulate.sv =====
// top level of the finite element rhs scatter accumulator
// Input channel (in_valid/in_ready) takes one request beat: accumulate a term
// weight*value*basis into the 3-vector at in_dof_index, read that entry, or read
// and clear it. Read requests give one beat on the output channel
// (out_valid/out_ready); accumulates and the unused code give none.
// One request is in progress at a time. An accumulate occupies the block
// until its term leaves the 5-stage term multiplier pipeline and the
// read-modify-write of the store entry is done.
// A read goes through the store read, then the loading of the output register;
// out_valid rises once that register is loaded, which waits until it is free.
// After reset a clearing pass writes zero to every one of the DOF_COUNT (4096)
// store entries, one entry per cycle; in_ready stays low throughout.
// The output register holds a result until taken; a new request is accepted
// while it waits, and a following read waits in its output step until the
// register is free, so a stalled receiver eventually holds off the input.
// Saturating Q32.16 sums; indices at or beyond the store size read as zero.
module fem_rhs_scatter_accumulate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  frsa_pkg::idx_t      in_dof_index,
  input  frsa_pkg::val_t      in_weight,
  input  frsa_pkg::val_t      in_basis_value,
  input  frsa_pkg::val_t      in_value_x,
  input  frsa_pkg::val_t      in_value_y,
  input  frsa_pkg::val_t      in_value_z,
  output logic                out_valid,
  input  logic                out_ready,
  output frsa_pkg::idx_t      out_entry_index,
  output frsa_pkg::sum_t      out_sum_x,
  output frsa_pkg::sum_t      out_sum_y,
  output frsa_pkg::sum_t      out_sum_z
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_OUT
  } state_t;

  localparam frsa_pkg::addr_t LAST_ADDR = frsa_pkg::addr_t'(frsa_pkg::DOF_COUNT - 1);

  state_t               state_r;
  frsa_pkg::addr_t      clr_addr_r;
  frsa_pkg::req_t       req_r;
  frsa_pkg::idx_t       idx_r;
  logic                 ok_r;
  logic                 out_valid_r;
  frsa_pkg::idx_t       out_entry_index_r;
  frsa_pkg::entry_t     out_entry_r;

  frsa_pkg::req_t       in_req;
  logic                 in_ok;
  logic                 accept;
  logic                 out_load;
  logic                 term_valid;
  frsa_pkg::entry_t     term;
  frsa_pkg::entry_t     rd_data;
  frsa_pkg::entry_t     acc_sum;
  frsa_pkg::store_req_t st_req;

  function automatic frsa_pkg::addr_t idx_to_addr(input frsa_pkg::idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[frsa_pkg::ADDR_W-1:0];
  endfunction

  function automatic frsa_pkg::sum_t sat_add(input frsa_pkg::sum_t a, input frsa_pkg::sum_t t);
    logic signed [frsa_pkg::SUM_W:0] s;
    s = {a[frsa_pkg::SUM_W-1], a} + {t[frsa_pkg::SUM_W-1], t};
    if (s[frsa_pkg::SUM_W] != s[frsa_pkg::SUM_W-1]) begin
      return s[frsa_pkg::SUM_W] ? frsa_pkg::SUM_MIN : frsa_pkg::SUM_MAX;
    end
    return s[frsa_pkg::SUM_W-1:0];
  endfunction

  assign in_req   = frsa_pkg::req_t'(in_req_type);
  assign in_ok    = 32'(in_dof_index) < 32'(frsa_pkg::DOF_COUNT);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  frsa_term u_term (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept && (in_req == frsa_pkg::REQ_ACC) && in_ok),
    .weight      (in_weight),
    .basis_value (in_basis_value),
    .value_x     (in_value_x),
    .value_y     (in_value_y),
    .value_z     (in_value_z),
    .term_valid  (term_valid),
    .term        (term)
  );

  always_comb begin
    acc_sum.x = sat_add(rd_data.x, term.x);
    acc_sum.y = sat_add(rd_data.y, term.y);
    acc_sum.z = sat_add(rd_data.z, term.z);

    st_req.rd_en   = accept;
    st_req.rd_addr = idx_to_addr(in_dof_index);
    st_req.wr_en   = 1'b0;
    st_req.wr_addr = idx_to_addr(idx_r);
    st_req.wr_data = '0;
    priority if (state_r == ST_CLEAR) begin
      st_req.wr_en   = 1'b1;
      st_req.wr_addr = clr_addr_r;
    end else if ((state_r == ST_ACC) && term_valid) begin
      st_req.wr_en   = 1'b1;
      st_req.wr_data = acc_sum;
    end else if (out_load && (req_r == frsa_pkg::REQ_RDCLR) && ok_r) begin
      st_req.wr_en   = 1'b1;
    end else begin
      st_req.wr_en   = 1'b0;
    end
  end

  frsa_store u_store (
    .clk     (clk),
    .req     (st_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= frsa_pkg::addr_t'(clr_addr_r + 1'b1);
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_r <= in_req;
            idx_r <= in_dof_index;
            ok_r  <= in_ok;
            if ((in_req == frsa_pkg::REQ_ACC) && in_ok) begin
              state_r <= ST_ACC;
            end else if ((in_req == frsa_pkg::REQ_READ) || (in_req == frsa_pkg::REQ_RDCLR)) begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_ACC: begin
          if (term_valid) begin
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_entry_index_r <= idx_r;
            out_entry_r       <= ok_r ? rd_data : '0;
            state_r           <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_index = out_entry_index_r;
  assign out_sum_x       = out_entry_r.x;
  assign out_sum_y       = out_entry_r.y;
  assign out_sum_z       = out_entry_r.z;

  // a new result only comes from the output step
  a_out_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared outside the output step");

  // store never read and written in the same cycle
  a_no_read_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_req.rd_en && st_req.wr_en))
    else $error("store read and write collide");

  // a finished term always finds its accumulate waiting
  a_term_only_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
    term_valid |-> (state_r == ST_ACC))
    else $error("term finished with no accumulate in progress");

endmodule
